>>> sv/bba_pkg.sv
// Shared types and constants for the block bitmap allocator.
`default_nettype none

package bba_pkg;

  // Fixed field widths of the request and response items
  localparam int ENTRY_W    = 13;
  localparam int STATUS_W   = 2;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 16;
  localparam int CFG_DATA_W = 16;

  // Allocation limit after reset
  localparam logic [ENTRY_W-1:0] LIMIT_RESET = 13'd4096;

  // Request kinds carried on in_tuser
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE = 2'd0,
    STAT_FULL = 2'd1,
    STAT_BAD  = 2'd2
  } status_t;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_CHK,
    S_ALLOC_EVAL,
    S_FREE_SEEK,
    S_FREE_EVAL,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> sv/bba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> sv/block_bitmap_allocator_core.sv
// First-fit bitmap allocator: top level with scan sequencer and bitmap RAM.
//
//  channel | dir | handshake              | payload
//  --------+-----+------------------------+---------------------------------------
//  in_     | in  | in_tvalid / in_tready  | tuser: operation; tdata: entry_number
//  out_    | out | out_tvalid / out_tready| tdata: given_entry, status
//  cfg_    | in  | cfg_tvalid / cfg_tready| tdata: entries_in_use
//
// After reset a clearing pass writes all WORD_COUNT bitmap words (128 at the
// defaults) to zero, one word per cycle; no request is taken meanwhile.
// Allocate checks the limit, then scans the bitmap a word at a time through the
// single RAM read port, at most WORD_COUNT words. Free steps word by word to the
// entry's word, then clears its bit; a free of entry zero or of an entry beyond
// the pool is reported bad without a RAM access. One request is in flight at a
// time; the result waits in the output register until out_tready.
`default_nettype none

module block_bitmap_allocator_core
  import bba_pkg::*;
#(
  parameter int ENTRIES   = 4096,
  parameter int WORD_BITS = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // request stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [12:0] entry_number, [15:13] zero
  input  wire logic                  in_tuser,   // [0] operation
  // response stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic      [OUT_DATA_W-1:0] out_tdata,  // [12:0] given_entry, [14:13] status,
                                                 // [15] zero
  // limit register write
  input  wire logic                  cfg_tvalid,
  output logic                       cfg_tready,
  input  wire logic [CFG_DATA_W-1:0] cfg_tdata   // [12:0] entries_in_use, [15:13] zero
);

  localparam int WORD_COUNT = (ENTRIES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW         = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
  localparam int WC_W       = $clog2(WORD_COUNT + 1);
  localparam int BIT_W      = $clog2(WORD_BITS);
  localparam int SPAN_W     = $clog2(ENTRIES + 2 * WORD_BITS);
  localparam int VAL_W      = (SPAN_W > ENTRY_W) ? SPAN_W : ENTRY_W + 1;

  localparam logic [VAL_W-1:0] ENTRIES_V = VAL_W'(ENTRIES);
  localparam logic [VAL_W-1:0] STEP_V    = VAL_W'(WORD_BITS);
  localparam logic [WC_W-1:0]  LAST_WORD = WC_W'(WORD_COUNT - 1);

  state_t                 state_r, state_nxt;
  logic [WC_W-1:0]        w_r, w_nxt;
  logic [VAL_W-1:0]       base_r, base_nxt;
  logic [VAL_W-1:0]       limit_r, limit_nxt;
  logic [VAL_W-1:0]       idx_r, idx_nxt;
  logic [BIT_W-1:0]       bit_r, bit_nxt;
  logic [ENTRY_W-1:0]     given_r, given_nxt;
  status_t                status_r, status_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic [ENTRY_W-1:0]     limit_cfg_r;

  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [WORD_BITS-1:0]   ram_wdata;
  logic [AW-1:0]          ram_raddr;
  logic [WORD_BITS-1:0]   ram_rdata;

  logic [VAL_W-1:0]       base_step;
  logic [WC_W-1:0]        w_inc;
  logic [WORD_BITS-1:0]   avail;
  logic [BIT_W-1:0]       lo_bit;
  logic [VAL_W-1:0]       cand;
  logic [VAL_W-1:0]       req_entry;
  logic [VAL_W-1:0]       cfg_limit;

  // Bitmap store, one bit per entry, 1 = used
  bba_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (WORD_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Shared word stepper and lowest-free-bit encoder
  assign base_step = base_r + STEP_V;
  assign w_inc     = w_r + WC_W'(1);
  assign avail     = ~ram_rdata;
  assign cand      = base_r + VAL_W'(lo_bit) + VAL_W'(1);
  assign req_entry = VAL_W'(in_tdata[ENTRY_W-1:0]);
  assign cfg_limit = VAL_W'(limit_cfg_r);

  always_comb begin
    lo_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (avail[i]) begin
        lo_bit = BIT_W'(i);
      end
    end
  end

  // Port outputs
  assign in_tready  = (state_r == S_IDLE);
  assign cfg_tready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, status_r, given_r};

  // Limit register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_cfg_r <= LIMIT_RESET;
    end else if (cfg_tvalid && cfg_tready) begin
      limit_cfg_r <= cfg_tdata[ENTRY_W-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      w_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Working and result registers
  always_ff @(posedge clk) begin
    base_r   <= base_nxt;
    limit_r  <= limit_nxt;
    idx_r    <= idx_nxt;
    bit_r    <= bit_nxt;
    given_r  <= given_nxt;
    status_r <= status_nxt;
  end

  // Sequencer: next state, RAM access and result
  always_comb begin
    state_nxt     = state_r;
    w_nxt         = w_r;
    base_nxt      = base_r;
    limit_nxt     = limit_r;
    idx_nxt       = idx_r;
    bit_nxt       = bit_r;
    given_nxt     = given_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_waddr     = w_r[AW-1:0];
    ram_wdata     = '0;
    ram_raddr     = w_r[AW-1:0];

    unique case (state_r)
      S_CLEAR: begin
        // zero one word per cycle
        ram_we = 1'b1;
        if (w_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end else begin
          w_nxt = w_inc;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          w_nxt     = '0;
          base_nxt  = '0;
          limit_nxt = (cfg_limit > ENTRIES_V) ? ENTRIES_V : cfg_limit;
          idx_nxt   = req_entry - VAL_W'(1);
          if (in_tuser == OP_ALLOC) begin
            state_nxt = S_ALLOC_CHK;
          end else if (req_entry == '0 || req_entry > ENTRIES_V) begin
            given_nxt     = '0;
            status_nxt    = STAT_BAD;
            out_valid_nxt = 1'b1;
            state_nxt     = S_DONE;
          end else begin
            state_nxt = S_FREE_SEEK;
          end
        end
      end

      S_ALLOC_CHK: begin
        // first word: stop if the limit is zero, else fetch it
        if (base_r >= limit_r) begin
          given_nxt     = '0;
          status_nxt    = STAT_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          state_nxt = S_ALLOC_EVAL;
        end
      end

      S_ALLOC_EVAL: begin
        // look at the fetched word while fetching the next one
        ram_raddr = w_inc[AW-1:0];
        if (avail == '0) begin
          w_nxt    = w_inc;
          base_nxt = base_step;
          if (base_step >= limit_r) begin
            given_nxt     = '0;
            status_nxt    = STAT_FULL;
            out_valid_nxt = 1'b1;
            state_nxt     = S_DONE;
          end
        end else if (cand > limit_r) begin
          given_nxt     = '0;
          status_nxt    = STAT_FULL;
          out_valid_nxt = 1'b1;
          state_nxt     = S_DONE;
        end else begin
          ram_we        = 1'b1;
          ram_wdata     = ram_rdata | (WORD_BITS'(1) << lo_bit);
          given_nxt     = ENTRY_W'(cand);
          status_nxt    = STAT_DONE;
          out_valid_nxt = 1'b1;
          state_nxt     = S_DONE;
        end
      end

      S_FREE_SEEK: begin
        // step one word at a time until the entry's word is reached
        if (idx_r < base_step) begin
          bit_nxt   = BIT_W'(idx_r - base_r);
          state_nxt = S_FREE_EVAL;
        end else begin
          w_nxt    = w_inc;
          base_nxt = base_step;
        end
      end

      S_FREE_EVAL: begin
        // clear the used mark and write the word back
        ram_we        = 1'b1;
        ram_wdata     = ram_rdata & ~(WORD_BITS'(1) << bit_r);
        given_nxt     = '0;
        status_nxt    = STAT_DONE;
        out_valid_nxt = 1'b1;
        state_nxt     = S_DONE;
      end

      S_DONE: begin
        // hold the result until it is taken
        if (out_tready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> sv/bba_checker.sv
// Port-level checks for the block bitmap allocator, bound to the top level.
`default_nettype none

module bba_checker
  import bba_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_tvalid,
  input wire logic                  in_tready,
  input wire logic                  out_tvalid,
  input wire logic                  out_tready,
  input wire logic [OUT_DATA_W-1:0] out_tdata
);

  // A pending response holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("response changed or dropped before transfer");

  // One request in flight: never ready while a response waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("request accepted while a response is pending");

  // An accepted request closes the input until its response is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input still ready after a request transfer");

  // Only defined status codes, and no entry number with a failure status
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[14:13] == STAT_DONE || out_tdata[14:13] == STAT_FULL ||
                    out_tdata[14:13] == STAT_BAD))
    else $error("undefined status code");

  a_fail_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[14:13] != STAT_DONE |-> out_tdata[12:0] == '0)
    else $error("entry number given with a failure status");

endmodule

bind block_bitmap_allocator_core bba_checker u_bba_checker (.*);

`default_nettype wire

>>> test/tb_top.sv
// Self-checking testbench for the block bitmap allocator: directed and random request streams.
module tb_top;
  import bba_pkg::*;

  localparam int POOL      = 4096;
  localparam int MAX_SHOWN = 10;

  // One expected response of the allocator
  typedef struct packed {
    logic [ENTRY_W-1:0] given;
    status_t            status;
  } alloc_result_t;

  // Track pool occupancy and queue the response each request must produce
  class alloc_scoreboard;
    bit                 used_map [POOL];
    logic [ENTRY_W-1:0] limit;
    alloc_result_t      expected_q [$];
    int                 mismatches;
    int                 n_checked;
    int                 n_granted;
    int                 n_full;
    int                 n_released;
    int                 n_ignored;

    function new();
      limit = LIMIT_RESET;
    endfunction

    // Apply a request to the pool and queue its response
    function void note_request(logic op, logic [ENTRY_W-1:0] num);
      alloc_result_t r;
      int            top;
      r.given = '0;
      if (op == OP_ALLOC) begin
        r.status = STAT_FULL;
        top = (limit > POOL) ? POOL : int'(limit);
        for (int n = 1; n <= top; n++) begin
          if (!used_map[n-1]) begin
            used_map[n-1] = 1'b1;
            r.given  = ENTRY_W'(n);
            r.status = STAT_DONE;
            break;
          end
        end
      end else if (num == 0 || num > POOL) begin
        r.status = STAT_BAD;
      end else begin
        used_map[num-1] = 1'b0;
        r.status = STAT_DONE;
      end
      expected_q.push_back(r);
    endfunction

    // Compare one response transfer against the oldest queued response
    function void check_response(logic [OUT_DATA_W-1:0] word);
      alloc_result_t       want;
      logic [ENTRY_W-1:0]  got_entry;
      logic [STATUS_W-1:0] got_status;
      got_entry  = word[ENTRY_W-1:0];
      got_status = word[ENTRY_W +: STATUS_W];
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected response: entry %0d status %0d", got_entry, got_status));
        return;
      end
      want = expected_q.pop_front();
      n_checked++;
      case (want.status)
        STAT_FULL: n_full++;
        STAT_BAD:  n_ignored++;
        default: begin
          if (want.given != 0) n_granted++;
          else n_released++;
        end
      endcase
      if (got_entry !== want.given || got_status !== want.status)
        report($sformatf("response %0d: expected entry %0d status %s, got entry %0d status %0d",
                         n_checked, want.given, want.status.name(), got_entry, got_status));
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= MAX_SHOWN) $display("ERROR: %s", msg);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Return some entry currently in use, or zero when the pool is empty
    function logic [ENTRY_W-1:0] pick_used();
      int start;
      int idx;
      start = $urandom_range(POOL - 1, 0);
      for (int i = 0; i < POOL; i++) begin
        idx = (start + i) % POOL;
        if (used_map[idx]) return ENTRY_W'(idx + 1);
      end
      return '0;
    endfunction
  endclass

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // [12:0] entry_number, [15:13] zero
  logic                  in_tuser   = 1'b0;  // [0] operation
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;  // [12:0] given_entry, [14:13] status, [15] zero
  logic                  cfg_tvalid = 1'b0;
  logic                  cfg_tready;
  logic [CFG_DATA_W-1:0] cfg_tdata  = '0;  // [12:0] entries_in_use, [15:13] zero

  alloc_scoreboard sb = new();
  int burst_left = 0;
  int n_writes   = 0;

  // Limit settings of the random phases and the request count of each
  int phase_limit [11] = '{40, 8191, 0, 33, 1, 64, 5000, 2, 32, 4096, 100};
  int phase_items [11] = '{120, 100, 30, 120, 60, 120, 100, 60, 120, 120, 150};

  block_bitmap_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_tvalid (cfg_tvalid),
    .cfg_tready (cfg_tready),
    .cfg_tdata  (cfg_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Check every response transfer
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_response(out_tdata);
  end

  // Stall the response side in stretches: always ready, random, or periodic
  initial begin
    int span;
    int mode;
    int hold;
    forever begin
      span = $urandom_range(200, 20);
      mode = $urandom_range(2, 0);
      hold = $urandom_range(12, 2);
      for (int c = 0; c < span; c++) begin
        @(negedge clk);
        case (mode)
          0:       out_tready <= 1'b1;
          1:       out_tready <= ($urandom_range(9, 0) < 7);
          default: out_tready <= ((c % (hold + 3)) >= hold);
        endcase
      end
    end
  end

  // Drive one request, wait for its transfer, then maybe idle between bursts
  task automatic send_request(logic op, logic [ENTRY_W-1:0] num);
    in_tuser  <= op;
    in_tdata  <= {{(IN_DATA_W - ENTRY_W){1'b0}}, num};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    sb.note_request(op, num);
    @(negedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(12, 1);
      if ($urandom_range(3, 0) != 0) begin
        in_tvalid <= 1'b0;
        repeat ($urandom_range(15, 1)) @(negedge clk);
      end
    end
  endtask

  // Hold off requests until every queued response has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Write the allocation limit while the block is idle
  task automatic write_limit(logic [ENTRY_W-1:0] value);
    drain();
    cfg_tdata  <= {{(CFG_DATA_W - ENTRY_W){1'b0}}, value};
    cfg_tvalid <= 1'b1;
    do @(posedge clk); while (!cfg_tready);
    sb.limit = value;
    n_writes++;
    @(negedge clk);
    cfg_tvalid <= 1'b0;
  endtask

  // Mostly allocate and release used entries; the rest frees zero, random or out-of-range entries
  task automatic run_random(logic [ENTRY_W-1:0] value, int items);
    int                 pick;
    logic [ENTRY_W-1:0] num;
    write_limit(value);
    repeat (items) begin
      pick = $urandom_range(99, 0);
      num  = ENTRY_W'($urandom);
      if (pick < 50) begin
        send_request(OP_ALLOC, num);
      end else if (pick < 85) begin
        send_request(OP_FREE, sb.pick_used());
      end else begin
        case ($urandom_range(3, 0))
          0:       num = '0;
          1:       num = ENTRY_W'($urandom_range(POOL, 1));
          2:       num = ENTRY_W'($urandom_range(8191, POOL + 1));
          default: ;
        endcase
        send_request(OP_FREE, num);
      end
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    // Reset limit: basic grants, reuse, bad entries and double release
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_FREE, 13'd2);
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_FREE, 13'd0);
    send_request(OP_FREE, 13'd4096);
    send_request(OP_FREE, 13'd4097);
    send_request(OP_FREE, 13'd8191);
    send_request(OP_FREE, 13'd2);
    send_request(OP_FREE, 13'd2);

    // Zero limit reports full
    write_limit(13'd0);
    send_request(OP_ALLOC, ENTRY_W'($urandom));

    // Single-entry pool
    write_limit(13'd1);
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_FREE, 13'd1);
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_ALLOC, ENTRY_W'($urandom));

    // Limit above the pool size
    write_limit(13'd8191);
    send_request(OP_ALLOC, ENTRY_W'($urandom));

    // Fill to a small limit, then lower it below entries in use
    write_limit(13'd6);
    repeat (4) send_request(OP_ALLOC, ENTRY_W'($urandom));
    write_limit(13'd2);
    send_request(OP_FREE, 13'd5);
    send_request(OP_ALLOC, ENTRY_W'($urandom));
    send_request(OP_FREE, 13'd2);
    send_request(OP_ALLOC, ENTRY_W'($urandom));

    foreach (phase_limit[i]) run_random(ENTRY_W'(phase_limit[i]), phase_items[i]);

    drain();
    repeat (140) @(negedge clk);

    $display("Checked %0d responses: %0d grants, %0d pool-full, %0d releases, %0d ignored frees.",
             sb.n_checked, sb.n_granted, sb.n_full, sb.n_released, sb.n_ignored);
    $display("Limit register written %0d times, settings from 0 to 8191; %0d mismatches.",
             n_writes, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("block_bitmap_allocator_core: match");
    end else begin
      $display("block_bitmap_allocator_core: mismatch");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("block_bitmap_allocator_core: mismatch");
    $finish;
  end

endmodule
